FILE: hdl/vcrle_pkg.sv
package vcrle_pkg;

  // Payload layout
  localparam logic [7:0] PAYLOAD_VERSION = 8'd1;
  localparam logic [2:0] HEADER_BYTES    = 3'd6;  // version, x, y, z, count hi, count lo
  localparam logic [2:0] RUN_LAST        = 3'd6;  // index of final byte in a 7-byte record

  // Header byte positions
  localparam logic [2:0] HDR_VERSION  = 3'd0;
  localparam logic [2:0] HDR_EDGE_X   = 3'd1;
  localparam logic [2:0] HDR_EDGE_Y   = 3'd2;
  localparam logic [2:0] HDR_EDGE_Z   = 3'd3;
  localparam logic [2:0] HDR_COUNT_HI = 3'd4;

  // Limits
  localparam logic [7:0]  CHUNK_EDGE = 8'd32;
  localparam logic [16:0] MAX_CELLS  = 17'd32768;
  localparam logic [16:0] SAT17      = 17'h1FFFF;
  localparam logic [15:0] SAT16      = 16'hFFFF;

  typedef enum logic [2:0] {
    STATUS_OK,
    STATUS_HEADER,
    STATUS_DIMENSIONS,
    STATUS_RUN_LAYOUT,
    STATUS_RUN_LENGTH,
    STATUS_CELL_COUNT
  } status_t;

  typedef struct packed {
    logic        run_valid;
    logic [7:0]  run_material;
    logic [31:0] run_flags;
    logic [15:0] run_length;
    logic [15:0] start_cell;
    logic        verdict_valid;
    status_t     status;
    logic [7:0]  edge_x;
    logic [7:0]  edge_y;
    logic [7:0]  edge_z;
  } result_t;

endpackage

FILE: hdl/vcrle_if.sv
interface vcrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vcrle_out_if;
  logic        valid;
  logic        ready;
  logic        run_valid;
  logic [7:0]  run_material;
  logic [31:0] run_flags;
  logic [15:0] run_length;
  logic [15:0] start_cell;
  logic        verdict_valid;
  logic [2:0]  status;
  logic [7:0]  edge_x;
  logic [7:0]  edge_y;
  logic [7:0]  edge_z;

  modport source (output valid, output run_valid, output run_material, output run_flags,
                  output run_length, output start_cell, output verdict_valid,
                  output status, output edge_x, output edge_y, output edge_z,
                  input ready);
  modport sink   (input valid, input run_valid, input run_material, input run_flags,
                  input run_length, input start_cell, input verdict_valid,
                  input status, input edge_x, input edge_y, input edge_z,
                  output ready);
endinterface

FILE: hdl/vcrle_parser.sv
module vcrle_parser
  import vcrle_pkg::*;
#(
  parameter logic [7:0]  EDGE_LIMIT = CHUNK_EDGE,
  parameter logic [16:0] CELL_LIMIT = MAX_CELLS
)
(
  input  logic          clk,
  input  logic          rst,
  vcrle_in_if.sink      in_ch,
  input  logic          accept_ok,
  output logic          produce,
  output result_t       result
);

  logic [2:0]  header_index, header_index_next;
  logic        header_bad, header_bad_next;
  logic [7:0]  size_x_reg, size_x_next;
  logic [7:0]  size_y_reg, size_y_next;
  logic [7:0]  size_z_reg, size_z_next;
  logic [16:0] cells_expected, cells_expected_next;
  logic [15:0] runs_declared, runs_declared_next;
  logic [16:0] runs_seen, runs_seen_next;
  logic [2:0]  run_byte_index, run_byte_index_next;
  logic [47:0] run_bytes, run_bytes_next;   // first six bytes of the record
  logic [16:0] cells_filled, cells_filled_next;
  logic        length_fault, length_fault_next;

  logic        fire;
  logic        run_done;
  logic [15:0] rec_len;
  logic [17:0] fill_sum;
  logic [16:0] remaining;
  logic [24:0] product;
  logic [16:0] product_sat;
  status_t     verdict;

  assign in_ch.ready = accept_ok;
  assign fire        = in_ch.valid && accept_ok;

  assign rec_len     = {run_bytes[7:0], in_ch.data_byte};
  assign fill_sum    = {1'b0, cells_filled} + {2'b00, rec_len};
  assign remaining   = (cells_expected > cells_filled) ? (cells_expected - cells_filled) : 17'd0;
  assign product     = cells_expected * {9'd0, in_ch.data_byte};
  assign product_sat = (product[24:17] != 8'd0) ? SAT17 : product[16:0];

  always_comb begin
    header_index_next   = header_index;
    header_bad_next     = header_bad;
    size_x_next         = size_x_reg;
    size_y_next         = size_y_reg;
    size_z_next         = size_z_reg;
    cells_expected_next = cells_expected;
    runs_declared_next  = runs_declared;
    runs_seen_next      = runs_seen;
    run_byte_index_next = run_byte_index;
    run_bytes_next      = run_bytes;
    cells_filled_next   = cells_filled;
    length_fault_next   = length_fault;
    run_done            = 1'b0;

    if (header_index != HEADER_BYTES) begin
      header_index_next = header_index + 3'd1;
      unique case (header_index)
        HDR_VERSION: begin
          header_bad_next = (in_ch.data_byte != PAYLOAD_VERSION);
        end
        HDR_EDGE_X: begin
          size_x_next         = in_ch.data_byte;
          cells_expected_next = {9'd0, in_ch.data_byte};
        end
        HDR_EDGE_Y: begin
          size_y_next         = in_ch.data_byte;
          cells_expected_next = product_sat;
        end
        HDR_EDGE_Z: begin
          size_z_next         = in_ch.data_byte;
          cells_expected_next = product_sat;
        end
        HDR_COUNT_HI: begin
          runs_declared_next = {in_ch.data_byte, 8'h00};
        end
        default: begin
          runs_declared_next = {runs_declared[15:8], in_ch.data_byte};
        end
      endcase
    end else begin
      run_bytes_next = {run_bytes[39:0], in_ch.data_byte};
      if (run_byte_index == RUN_LAST) begin
        run_byte_index_next = 3'd0;
        run_done            = 1'b1;
        if (!length_fault && (rec_len == 16'd0 || {1'b0, rec_len} > remaining)) begin
          length_fault_next = 1'b1;
        end
        cells_filled_next = fill_sum[17] ? SAT17 : fill_sum[16:0];
        runs_seen_next    = (runs_seen != SAT17) ? runs_seen + 17'd1 : SAT17;
      end else begin
        run_byte_index_next = run_byte_index + 3'd1;
      end
    end
  end

  // Verdict on post-update state; cells_expected only moves while the header is
  // still short, where the header check already wins.
  always_comb begin
    priority if (header_index_next != HEADER_BYTES || header_bad_next) begin
      verdict = STATUS_HEADER;
    end else if (size_x_next == 8'd0 || size_x_next > EDGE_LIMIT ||
                 size_y_next == 8'd0 || size_y_next > EDGE_LIMIT ||
                 size_z_next == 8'd0 || size_z_next > EDGE_LIMIT) begin
      verdict = STATUS_DIMENSIONS;
    end else if (runs_declared_next == 16'd0 ||
                 {1'b0, runs_declared_next} > cells_expected ||
                 run_byte_index_next != 3'd0 ||
                 runs_seen_next != {1'b0, runs_declared_next}) begin
      verdict = STATUS_RUN_LAYOUT;
    end else if (length_fault_next) begin
      verdict = STATUS_RUN_LENGTH;
    end else if (cells_filled_next != cells_expected || cells_expected == 17'd0 ||
                 cells_expected > CELL_LIMIT) begin
      verdict = STATUS_CELL_COUNT;
    end else begin
      verdict = STATUS_OK;
    end
  end

  always_comb begin
    result.run_valid     = run_done;
    result.run_material  = run_done ? run_bytes[47:40] : 8'd0;
    result.run_flags     = run_done ? run_bytes[39:8]  : 32'd0;
    result.run_length    = run_done ? rec_len          : 16'd0;
    result.start_cell    = !run_done ? 16'd0 : (cells_filled[16] ? SAT16 : cells_filled[15:0]);
    result.verdict_valid = in_ch.last_byte;
    result.status        = in_ch.last_byte ? verdict     : STATUS_OK;
    result.edge_x        = in_ch.last_byte ? size_x_next : 8'd0;
    result.edge_y        = in_ch.last_byte ? size_y_next : 8'd0;
    result.edge_z        = in_ch.last_byte ? size_z_next : 8'd0;
  end

  assign produce = fire && (run_done || in_ch.last_byte);

  always_ff @(posedge clk) begin
    if (rst || (fire && in_ch.last_byte)) begin
      header_index   <= 3'd0;
      header_bad     <= 1'b0;
      size_x_reg     <= 8'd0;
      size_y_reg     <= 8'd0;
      size_z_reg     <= 8'd0;
      cells_expected <= 17'd0;
      runs_declared  <= 16'd0;
      runs_seen      <= 17'd0;
      run_byte_index <= 3'd0;
      cells_filled   <= 17'd0;
      length_fault   <= 1'b0;
    end else if (fire) begin
      header_index   <= header_index_next;
      header_bad     <= header_bad_next;
      size_x_reg     <= size_x_next;
      size_y_reg     <= size_y_next;
      size_z_reg     <= size_z_next;
      cells_expected <= cells_expected_next;
      runs_declared  <= runs_declared_next;
      runs_seen      <= runs_seen_next;
      run_byte_index <= run_byte_index_next;
      cells_filled   <= cells_filled_next;
      length_fault   <= length_fault_next;
    end
  end

  // record bytes are all replaced before use, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      run_bytes <= run_bytes_next;
    end
  end

  a_header_range: assert property (@(posedge clk) disable iff (rst)
    header_index <= HEADER_BYTES)
    else $error("header index out of range");

  a_body_after_header: assert property (@(posedge clk) disable iff (rst)
    (run_byte_index != 3'd0 || runs_seen != 17'd0) |-> header_index == HEADER_BYTES)
    else $error("run record progress before header complete");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_ch.last_byte |=> header_index == 3'd0 && run_byte_index == 3'd0 &&
                               cells_filled == 17'd0)
    else $error("state not cleared after last beat");

endmodule

FILE: hdl/vcrle_out_stage.sv
module vcrle_out_stage
  import vcrle_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          produce,
  input  result_t       result,
  output logic          accept_ok,
  vcrle_out_if.source   out_ch
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    slot_free;

  assign slot_free = !out_valid || out_ch.ready;
  assign accept_ok = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (produce) begin
        out_data <= result;
      end
    end else if (produce) begin
      skid_data <= result;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.run_valid     = out_data.run_valid;
  assign out_ch.run_material  = out_data.run_material;
  assign out_ch.run_flags     = out_data.run_flags;
  assign out_ch.run_length    = out_data.run_length;
  assign out_ch.start_cell    = out_data.start_cell;
  assign out_ch.verdict_valid = out_data.verdict_valid;
  assign out_ch.status        = out_data.status;
  assign out_ch.edge_x        = out_data.edge_x;
  assign out_ch.edge_y        = out_data.edge_y;
  assign out_ch.edge_z        = out_data.edge_z;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_beat_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.run_valid || out_data.verdict_valid))
    else $error("empty result beat offered");

  a_no_produce_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !produce)
    else $error("result produced while skid full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ch.ready |=> out_valid && !skid_valid)
    else $error("skid beat not moved to output register");

endmodule

FILE: hdl/voxel_cell_rle_decoder.sv
// Output: each accepted beat's result (run record and/or verdict) is registered
//   in the output register, or in the skid while the sink stalls.
// Throughput: one byte per cycle while ready is high; one small update of the parse
//   state per beat, and a two-deep output register/skid keeps input flowing while a result waits.
// Reset: synchronous, active high; clears the parse state and both output slots.
//   The parse state also returns to reset after every beat marked last.
module voxel_cell_rle_decoder
  import vcrle_pkg::*;
#(
  parameter logic [7:0]  EDGE_LIMIT = CHUNK_EDGE,  // largest legal edge size
  parameter logic [16:0] CELL_LIMIT = MAX_CELLS    // largest legal cell volume
)
(
  input  logic        clk,
  input  logic        rst,
  vcrle_in_if.sink    in_ch,
  vcrle_out_if.source out_ch
);

  // Parser: header fields, record assembly, running cell sum and the verdict are
  // all worked out combinationally from the current beat and the parse registers.
  // Only beats that complete a run or carry the last byte produce a result.
  logic    produce;
  logic    accept_ok;
  result_t result;

  vcrle_parser #(
    .EDGE_LIMIT (EDGE_LIMIT),
    .CELL_LIMIT (CELL_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .accept_ok (accept_ok),
    .produce   (produce),
    .result    (result)
  );

  // Output register plus skid: input ready drops only while the skid is full,
  // i.e. after the sink has stalled with a beat already waiting.
  vcrle_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .produce   (produce),
    .result    (result),
    .accept_ok (accept_ok),
    .out_ch    (out_ch)
  );

endmodule
